// ----- rtl/mlbf_pkg.sv -----
// ----------------------------------------------------------------------------
// mlbf_pkg
// Shared codes, widths and the per-LED pattern entry of the LED controller.
// ----------------------------------------------------------------------------
package mlbf_pkg;

  localparam int MODE_W    = 3;
  localparam int LED_W     = 3;
  localparam int CNT_W     = 16;
  localparam int MASK_W    = 7;
  localparam int LCOUNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int DEF_NUM_LEDS = 7;

  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OFF   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLINK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_OFF    = 3'd5;

  localparam logic [CNT_W-1:0] BLINK_ON_RST  = 16'd500;
  localparam logic [CNT_W-1:0] BLINK_OFF_RST = 16'd500;
  localparam logic [CNT_W-1:0] FLASH_ON_RST  = 16'd100;
  localparam logic [CNT_W-1:0] FLASH_OFF_RST = 16'd900;

  typedef struct packed {
    logic             flash;
    logic [CNT_W-1:0] pulses;
    logic [CNT_W-1:0] elapsed;
  } entry_t;

endpackage

// ----- rtl/multi_led_blink_flash_controller.sv -----
// ----------------------------------------------------------------------------
// multi_led_blink_flash_controller
// Per-LED on/off/blink/flash control driven by commands and 1 ms tick items.
// ----------------------------------------------------------------------------
// One item is handled at a time. A command goes to S_DONE, where its result is
// registered. A tick runs S_WALK, S_DRAIN, S_DONE and walks the pattern memory
// one LED per cycle, reading one entry while the previous one is written back.
// Pin levels and pattern flags live in flip-flops; each patterned LED keeps
// its kind, remaining pulses and elapsed time in a one-port-read memory.
// The next item is accepted while the previous result waits to be taken.
module multi_led_blink_flash_controller #(
  parameter int NUM_LEDS = mlbf_pkg::DEF_NUM_LEDS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mlbf_pkg::MODE_W-1:0]         mode,
  input  logic [mlbf_pkg::LED_W-1:0]          led,
  input  logic [mlbf_pkg::CNT_W-1:0]          repeat_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mlbf_pkg::MASK_W-1:0]         pin_levels,
  output logic [mlbf_pkg::MASK_W-1:0]         pattern_active,
  output logic                                accepted,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlbf_pkg::CFG_W-1:0]          cfg_data
);
  import mlbf_pkg::*;

  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LW-1:0] LAST_IDX = LW'(NUM_LEDS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [LCOUNT_W-1:0] led_count;
  logic [MASK_W-1:0]   enabled_mask;
  logic [CNT_W-1:0]    blink_on_ms, blink_off_ms, flash_on_ms, flash_off_ms;

  logic [NUM_LEDS-1:0] pin_q, pattern_q;
  logic                acc_q;

  entry_t              mem [NUM_LEDS];
  entry_t              rdata;
  logic [LW-1:0]       rd_idx;
  logic                p_valid;
  logic [LW-1:0]       p_idx;

  logic                in_acc, cmd_ok, cmd_acc, cmd_pat;
  logic [LW-1:0]       led_idx;
  logic                p_go, pin_new, pat_new;
  logic [CNT_W-1:0]    e_inc, on_p, off_p;
  entry_t              wr_tick, wr_cmd, mem_wd;
  logic                mem_we;
  logic [LW-1:0]       mem_wa;
  logic                out_free;

  function automatic logic chan_ok(input logic [5:0] idx,
                                   input logic [LCOUNT_W-1:0] cnt,
                                   input logic [MASK_W-1:0] msk);
    chan_ok = (idx < {3'b000, cnt}) && (idx < 6'(NUM_LEDS)) &&
              (idx < 6'(MASK_W)) && msk[idx[2:0]];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count    <= '0;
      enabled_mask <= '0;
      blink_on_ms  <= BLINK_ON_RST;
      blink_off_ms <= BLINK_OFF_RST;
      flash_on_ms  <= FLASH_ON_RST;
      flash_off_ms <= FLASH_OFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LED_COUNT:    led_count    <= cfg_data[LCOUNT_W-1:0];
        REG_ENABLED_MASK: enabled_mask <= cfg_data[MASK_W-1:0];
        REG_BLINK_ON:     blink_on_ms  <= cfg_data;
        REG_BLINK_OFF:    blink_off_ms <= cfg_data;
        REG_FLASH_ON:     flash_on_ms  <= cfg_data;
        REG_FLASH_OFF:    flash_off_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign led_idx  = LW'(led);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd_ok  = in_acc && (mode != MODE_TICK) && (mode <= MODE_FLASH) &&
              chan_ok(6'(led), led_count, enabled_mask);
    cmd_pat = cmd_ok && ((mode == MODE_BLINK) || (mode == MODE_FLASH));
    cmd_acc = 1'b0;
    if (cmd_ok) begin
      unique case (mode)
        MODE_ON:  cmd_acc = !pin_q[led_idx];
        MODE_OFF: cmd_acc = pin_q[led_idx];
        default:  cmd_acc = 1'b1;
      endcase
    end
    wr_cmd.flash   = (mode == MODE_FLASH);
    wr_cmd.pulses  = repeat_count;
    wr_cmd.elapsed = '0;
  end

  always_comb begin
    p_go    = p_valid && chan_ok(6'(p_idx), led_count, enabled_mask) && pattern_q[p_idx];
    e_inc   = (rdata.elapsed == '1) ? rdata.elapsed : rdata.elapsed + 16'd1;
    on_p    = rdata.flash ? flash_on_ms : blink_on_ms;
    off_p   = rdata.flash ? flash_off_ms : blink_off_ms;
    wr_tick = rdata;
    wr_tick.elapsed = e_inc;
    pin_new = pin_q[p_idx];
    pat_new = 1'b1;
    if (pin_q[p_idx]) begin
      if (e_inc >= on_p) begin
        pin_new = 1'b0;
        wr_tick.elapsed = '0;
        if (rdata.pulses != '0) begin
          wr_tick.pulses = rdata.pulses - 16'd1;
          if (rdata.pulses == 16'd1) pat_new = 1'b0;
        end
      end
    end else if (e_inc >= off_p) begin
      pin_new = 1'b1;
      wr_tick.elapsed = '0;
    end
    mem_we = p_go || cmd_pat;
    mem_wa = p_go ? p_idx : led_idx;
    mem_wd = p_go ? wr_tick : wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state == S_WALK) begin
      rdata <= mem[rd_idx];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) state_next = (mode == MODE_TICK) ? S_WALK : S_DONE;
      end
      S_WALK: begin
        if (rd_idx == LAST_IDX) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_idx    <= '0;
      p_valid   <= 1'b0;
      pin_q     <= '0;
      pattern_q <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == S_WALK);
      if (state == S_WALK) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
      end
      if (p_go) begin
        pin_q[p_idx]     <= pin_new;
        pattern_q[p_idx] <= pat_new;
      end else if (cmd_acc) begin
        pin_q[led_idx]     <= (mode != MODE_OFF);
        pattern_q[led_idx] <= cmd_pat;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= rd_idx;
    if (in_acc) begin
      acc_q <= (mode == MODE_TICK) || cmd_acc;
    end
    if ((state == S_DONE) && out_free) begin
      pin_levels     <= MASK_W'(pin_q);
      pattern_active <= MASK_W'(pattern_q);
      accepted       <= acc_q;
    end
  end

endmodule
